// ===== src/i2cm_pkg.sv =====
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam int ERR_CNT_W_DEF = 16;
    localparam int ERR_OUT_W     = 16;

    localparam logic [7:0]  HALF_BIT_RST  = 8'd2;
    localparam logic [7:0]  START_STOP_RST = 8'd4;
    localparam logic [9:0]  POLL_LIMIT_RST = 10'd250;
    localparam logic [15:0] RECOVERY_RST  = 16'd10000;

    localparam logic [1:0] CFG_HALF_BIT   = 2'd0;
    localparam logic [1:0] CFG_START_STOP = 2'd1;
    localparam logic [1:0] CFG_POLL_LIMIT = 2'd2;
    localparam logic [1:0] CFG_RECOVERY   = 2'd3;

    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NACK_ADDRW = 2'd1;
    localparam logic [1:0] ST_NACK_REG   = 2'd2;
    localparam logic [1:0] ST_NACK_ADDRR = 2'd3;

    localparam logic [1:0] STG_ADDR_W = 2'd0;
    localparam logic [1:0] STG_REG    = 2'd1;
    localparam logic [1:0] STG_DATA   = 2'd2;
    localparam logic [1:0] STG_ADDR_R = 2'd3;

    localparam logic [2:0] LAST_BIT = 3'd7;

    typedef struct packed {
        logic [7:0]  half_bit_ticks;
        logic [7:0]  start_stop_ticks;
        logic [9:0]  ack_poll_limit;
        logic [15:0] write_recovery_ticks;
    } cfg_t;

    typedef struct packed {
        logic       sda_sample;
        logic [7:0] read_count;
        logic [7:0] write_data;
        logic [7:0] register_address;
        logic [6:0] device_address;
        logic [1:0] command;
    } tick_item_t;

    typedef struct packed {
        logic [15:0] error_count;
        logic [1:0]  status;
        logic        done_res;
        logic        read_last;
        logic [7:0]  read_byte;
        logic        read_valid;
        logic        busy_res;
        logic        sda_drive_enable;
        logic        sda_level;
        logic        scl_level;
    } tick_result_t;

endpackage

// ===== src/i2cm_sequencer.sv =====
`timescale 1ns / 1ps

module i2cm_sequencer
    import i2cm_pkg::*;
#(
    parameter int ERROR_COUNT_WIDTH = ERR_CNT_W_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step_en,
    input  tick_item_t   item,
    input  cfg_t         cfg,
    output tick_result_t result
);

    localparam logic [3:0] P_IDLE      = 4'd0;
    localparam logic [3:0] P_START_HI  = 4'd1;
    localparam logic [3:0] P_START_LO  = 4'd2;
    localparam logic [3:0] P_TX_LOW    = 4'd3;
    localparam logic [3:0] P_TX_HIGH   = 4'd4;
    localparam logic [3:0] P_ACK_LOW   = 4'd5;
    localparam logic [3:0] P_ACK_POLL  = 4'd6;
    localparam logic [3:0] P_RX_LOW    = 4'd7;
    localparam logic [3:0] P_RX_HIGH   = 4'd8;
    localparam logic [3:0] P_MACK_LOW  = 4'd9;
    localparam logic [3:0] P_MACK_HIGH = 4'd10;
    localparam logic [3:0] P_STOP_LO   = 4'd11;
    localparam logic [3:0] P_STOP_HI   = 4'd12;
    localparam logic [3:0] P_RECOVER   = 4'd13;

    logic [3:0]  phase_reg, phase_next;
    logic [15:0] tick_reg, tick_next;
    logic [2:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic [9:0]  poll_reg, poll_next;
    logic [7:0]  left_reg, left_next;
    logic [6:0]  dev_reg, dev_next;
    logic [7:0]  regaddr_reg, regaddr_next;
    logic [7:0]  data_reg, data_next;
    logic [ERROR_COUNT_WIDTH-1:0] fail_reg, fail_next;
    logic        is_read_reg, is_read_next;
    logic [1:0]  stage_reg, stage_next;
    logic [1:0]  end_st_reg, end_st_next;
    logic        end_rec_reg, end_rec_next;

    logic [15:0] timer_len;
    logic [15:0] timer_eff;
    logic [16:0] tick_inc;
    logic        timer_done;
    logic [15:0] timer_tick;
    logic [7:0]  rx_shift;
    logic        last_byte;
    logic [31:0] fail_ext;

    always_comb
    begin
        case (phase_reg)
            P_START_HI, P_START_LO, P_STOP_LO, P_STOP_HI:
                timer_len = {8'd0, cfg.start_stop_ticks};
            P_RECOVER:
                timer_len = cfg.write_recovery_ticks;
            default:
                timer_len = {8'd0, cfg.half_bit_ticks};
        endcase
    end

    assign timer_eff  = (timer_len == 16'd0) ? 16'd1 : timer_len;
    assign tick_inc   = {1'b0, tick_reg} + 17'd1;
    assign timer_done = tick_inc >= {1'b0, timer_eff};
    assign timer_tick = timer_done ? 16'd0 : tick_inc[15:0];
    assign rx_shift   = {shift_reg[6:0], item.sda_sample};
    assign last_byte  = left_reg <= 8'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        poll_next    = poll_reg;
        left_next    = left_reg;
        dev_next     = dev_reg;
        regaddr_next = regaddr_reg;
        data_next    = data_reg;
        fail_next    = fail_reg;
        is_read_next = is_read_reg;
        stage_next   = stage_reg;
        end_st_next  = end_st_reg;
        end_rec_next = end_rec_reg;

        result                  = '0;
        result.scl_level        = 1'b1;
        result.sda_level        = 1'b1;
        result.sda_drive_enable = 1'b1;
        result.busy_res         = 1'b1;

        case (phase_reg)
            P_START_HI:
            begin
                tick_next = timer_tick;
                if (timer_done)
                begin
                    phase_next = P_START_LO;
                end
            end
            P_START_LO:
            begin
                result.sda_level = 1'b0;
                tick_next = timer_tick;
                if (timer_done)
                begin
                    shift_next = {dev_reg, stage_reg == STG_ADDR_R};
                    bit_next   = 3'd0;
                    phase_next = P_TX_LOW;
                end
            end
            P_TX_LOW:
            begin
                result.scl_level = 1'b0;
                result.sda_level = shift_reg[7];
                tick_next = timer_tick;
                if (timer_done)
                begin
                    phase_next = P_TX_HIGH;
                end
            end
            P_TX_HIGH:
            begin
                result.sda_level = shift_reg[7];
                tick_next = timer_tick;
                if (timer_done)
                begin
                    if (bit_reg == LAST_BIT)
                    begin
                        poll_next  = 10'd0;
                        phase_next = P_ACK_LOW;
                    end
                    else
                    begin
                        bit_next   = bit_reg + 3'd1;
                        shift_next = {shift_reg[6:0], 1'b0};
                        phase_next = P_TX_LOW;
                    end
                end
            end
            P_ACK_LOW:
            begin
                result.scl_level        = 1'b0;
                result.sda_drive_enable = 1'b0;
                tick_next = timer_tick;
                if (timer_done)
                begin
                    phase_next = P_ACK_POLL;
                end
            end
            P_ACK_POLL:
            begin
                result.sda_drive_enable = 1'b0;
                if (!item.sda_sample)
                begin
                    tick_next = 16'd0;
                    case (stage_reg)
                        STG_ADDR_W:
                        begin
                            stage_next = STG_REG;
                            shift_next = regaddr_reg;
                            bit_next   = 3'd0;
                            phase_next = P_TX_LOW;
                        end
                        STG_REG:
                        begin
                            if (is_read_reg)
                            begin
                                stage_next = STG_ADDR_R;
                                phase_next = P_START_HI;
                            end
                            else
                            begin
                                stage_next = STG_DATA;
                                shift_next = data_reg;
                                bit_next   = 3'd0;
                                phase_next = P_TX_LOW;
                            end
                        end
                        STG_DATA:
                        begin
                            end_st_next  = ST_OK;
                            end_rec_next = 1'b1;
                            phase_next   = P_STOP_LO;
                        end
                        default:
                        begin
                            bit_next   = 3'd0;
                            shift_next = 8'd0;
                            phase_next = P_RX_LOW;
                        end
                    endcase
                end
                else if (poll_reg >= cfg.ack_poll_limit)
                begin
                    tick_next  = 16'd0;
                    phase_next = P_STOP_LO;
                    if (stage_reg == STG_DATA)
                    begin
                        end_st_next  = ST_OK;
                        end_rec_next = 1'b1;
                    end
                    else
                    begin
                        end_rec_next = 1'b0;
                        case (stage_reg)
                            STG_ADDR_W: end_st_next = ST_NACK_ADDRW;
                            STG_REG:    end_st_next = ST_NACK_REG;
                            default:    end_st_next = ST_NACK_ADDRR;
                        endcase
                        if (is_read_reg && (fail_reg != '1))
                        begin
                            fail_next = fail_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    poll_next = poll_reg + 10'd1;
                end
            end
            P_RX_LOW:
            begin
                result.scl_level        = 1'b0;
                result.sda_drive_enable = 1'b0;
                tick_next = timer_tick;
                if (timer_done)
                begin
                    phase_next = P_RX_HIGH;
                end
            end
            P_RX_HIGH:
            begin
                result.sda_drive_enable = 1'b0;
                if (tick_reg == 16'd0)
                begin
                    shift_next = rx_shift;
                    if (bit_reg == LAST_BIT)
                    begin
                        result.read_valid = 1'b1;
                        result.read_byte  = rx_shift;
                        result.read_last  = last_byte;
                    end
                end
                tick_next = timer_tick;
                if (timer_done)
                begin
                    if (bit_reg == LAST_BIT)
                    begin
                        phase_next = P_MACK_LOW;
                    end
                    else
                    begin
                        bit_next   = bit_reg + 3'd1;
                        phase_next = P_RX_LOW;
                    end
                end
            end
            P_MACK_LOW, P_MACK_HIGH:
            begin
                result.scl_level = phase_reg != P_MACK_LOW;
                result.sda_level = last_byte;
                tick_next = timer_tick;
                if (timer_done)
                begin
                    if (phase_reg == P_MACK_LOW)
                    begin
                        phase_next = P_MACK_HIGH;
                    end
                    else if (last_byte)
                    begin
                        end_st_next  = ST_OK;
                        end_rec_next = 1'b0;
                        phase_next   = P_STOP_LO;
                    end
                    else
                    begin
                        left_next  = left_reg - 8'd1;
                        bit_next   = 3'd0;
                        shift_next = 8'd0;
                        phase_next = P_RX_LOW;
                    end
                end
            end
            P_STOP_LO:
            begin
                result.scl_level = 1'b0;
                result.sda_level = 1'b0;
                tick_next = timer_tick;
                if (timer_done)
                begin
                    phase_next = P_STOP_HI;
                end
            end
            P_STOP_HI:
            begin
                tick_next = timer_tick;
                if (timer_done)
                begin
                    if (end_rec_reg && (cfg.write_recovery_ticks != 16'd0))
                    begin
                        phase_next = P_RECOVER;
                    end
                    else
                    begin
                        result.done_res = 1'b1;
                        result.status   = end_st_reg;
                        phase_next      = P_IDLE;
                    end
                end
            end
            P_RECOVER:
            begin
                tick_next = timer_tick;
                if (timer_done)
                begin
                    result.done_res = 1'b1;
                    result.status   = end_st_reg;
                    phase_next      = P_IDLE;
                end
            end
            default:
            begin
                result.busy_res = 1'b0;
                phase_next      = P_IDLE;
                if ((item.command == CMD_WRITE) || (item.command == CMD_READ))
                begin
                    dev_next     = item.device_address;
                    regaddr_next = item.register_address;
                    data_next    = item.write_data;
                    left_next    = (item.read_count == 8'd0) ? 8'd1 : item.read_count;
                    is_read_next = item.command == CMD_READ;
                    stage_next   = STG_ADDR_W;
                    end_st_next  = ST_OK;
                    end_rec_next = 1'b0;
                    poll_next    = 10'd0;
                    bit_next     = 3'd0;
                    shift_next   = 8'd0;
                    tick_next    = 16'd0;
                    phase_next   = P_START_HI;
                end
            end
        endcase

        if (!result.sda_drive_enable)
        begin
            result.sda_level = 1'b1;
        end
        fail_ext           = 32'(fail_next);
        result.error_count = fail_ext[ERR_OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= P_IDLE;
            tick_reg    <= '0;
            bit_reg     <= '0;
            shift_reg   <= '0;
            poll_reg    <= '0;
            left_reg    <= '0;
            dev_reg     <= '0;
            regaddr_reg <= '0;
            data_reg    <= '0;
            fail_reg    <= '0;
            is_read_reg <= 1'b0;
            stage_reg   <= STG_ADDR_W;
            end_st_reg  <= ST_OK;
            end_rec_reg <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            poll_reg    <= poll_next;
            left_reg    <= left_next;
            dev_reg     <= dev_next;
            regaddr_reg <= regaddr_next;
            data_reg    <= data_next;
            fail_reg    <= fail_next;
            is_read_reg <= is_read_next;
            stage_reg   <= stage_next;
            end_st_reg  <= end_st_next;
            end_rec_reg <= end_rec_next;
        end
    end

endmodule

// ===== src/i2c_master_register_access_core.sv =====
`timescale 1ns / 1ps

// Channel    Direction  Signals                        Content
// s_axis     in         s_tvalid s_tready s_tdata      one bus tick with optional command
// m_axis     out        m_tvalid m_tready m_tdata      bus drive and status for that tick
//                       m_tlast                        last byte of a read burst
// cfg        in         cfg_valid cfg_ready            register index and write data
//                       cfg_index cfg_data
//
// One tick is accepted per clock cycle while m_axis is not stalled. The input register takes
// the tick at the accepting edge and the result register takes its result at the edge on
// which the stage advances; the result is then offered on m_axis from the result register.
// Reset clears the sequencer to idle and loads the register defaults.
// A stall on m_axis holds the result register and backs up into s_axis one stage later.

module i2c_master_register_access_core
    import i2cm_pkg::*;
#(
    parameter int ERROR_COUNT_WIDTH = ERR_CNT_W_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[1:0], device_address[8:2], register_address[16:9], write_data[24:17],
    // read_count[32:25], sda_sample[33], zero[39:34]
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // scl_level[0], sda_level[1], sda_drive_enable[2], busy_res[3], read_valid[4],
    // read_byte[12:5], done_res[13], status[15:14], error_count[31:16]
    output logic [31:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t         cfg_reg;
    logic         in_valid_reg;
    tick_item_t   in_item_reg;
    logic         out_valid_reg;
    tick_result_t out_res_reg;
    tick_result_t step_res;
    logic         advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_bit_ticks       <= HALF_BIT_RST;
            cfg_reg.start_stop_ticks     <= START_STOP_RST;
            cfg_reg.ack_poll_limit       <= POLL_LIMIT_RST;
            cfg_reg.write_recovery_ticks <= RECOVERY_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_HALF_BIT:   cfg_reg.half_bit_ticks       <= cfg_data[7:0];
                CFG_START_STOP: cfg_reg.start_stop_ticks     <= cfg_data[7:0];
                CFG_POLL_LIMIT: cfg_reg.ack_poll_limit       <= cfg_data[9:0];
                CFG_RECOVERY:   cfg_reg.write_recovery_ticks <= cfg_data;
                default:        cfg_reg.write_recovery_ticks <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg <= tick_item_t'(s_tdata[33:0]);
        end
        if (advance)
        begin
            out_res_reg <= step_res;
        end
    end

    i2cm_sequencer #(
        .ERROR_COUNT_WIDTH(ERROR_COUNT_WIDTH)
    ) u_sequencer (
        .clk    (clk),
        .rst_n  (rst_n),
        .step_en(advance),
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .result (step_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_res_reg.read_last;
    assign m_tdata  = {out_res_reg.error_count, out_res_reg.status, out_res_reg.done_res,
                       out_res_reg.read_byte, out_res_reg.read_valid, out_res_reg.busy_res,
                       out_res_reg.sda_drive_enable, out_res_reg.sda_level,
                       out_res_reg.scl_level};

endmodule
